>>> hw/rtl/rgb_deinterleave_normalize_macros.svh
// Assertion macros shared by the RGB deinterleave/normalize RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef RGB_DEINTERLEAVE_NORMALIZE_MACROS_SVH
`define RGB_DEINTERLEAVE_NORMALIZE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define RDN_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define RDN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/rdn_pkg.sv
// Types and constants for the RGB deinterleave/normalize block.
// No dependencies; imported by every RTL module of the block.
package rdn_pkg;

    localparam int DIM_BITS  = 16;
    localparam int ADDR_BITS = 6;
    localparam int DATA_BITS = 64;

    typedef enum logic [2:0] {
        REG_RED_COEF     = 3'd0,
        REG_GREEN_COEF   = 3'd1,
        REG_BLUE_COEF    = 3'd2,
        REG_CHANNEL_MAP  = 3'd3,
        REG_IMAGE_SIZE   = 3'd4,
        REG_OUTPUT_WIDTH = 3'd5,
        REG_PAD_OFFSET   = 3'd6
    } reg_idx_t;

    localparam logic [63:0] COEF_RESET        = 64'h0000_0000_0100_0000;
    localparam logic [5:0]  CHANNEL_MAP_RESET = 6'd36;
    localparam logic [15:0] OUT_WIDTH_RESET   = 16'd1;

    typedef struct packed {
        logic [63:0] red_coef;
        logic [63:0] green_coef;
        logic [63:0] blue_coef;
        logic [5:0]  channel_map;
        logic [31:0] image_size;
        logic [15:0] output_width;
        logic [31:0] pad_offset;
    } cfg_t;

    typedef struct packed {
        logic [7:0] pixel_byte_0;
        logic [7:0] pixel_byte_1;
        logic [7:0] pixel_byte_2;
        logic [7:0] pixel_byte_3;
    } in_beat_t;

    typedef struct packed {
        logic [31:0]        plane_index;
        logic signed [31:0] red_value;
        logic signed [31:0] green_value;
        logic signed [31:0] blue_value;
        logic               frame_end;
    } out_beat_t;

endpackage

>>> hw/rtl/rgb_deinterleave_normalize.sv
// Top level of the RGB deinterleave/normalize block. Pixels stream in one
// beat per clock; each beat is registered, then the channel pick, the three
// affine normalizers (one 9x32 multiply each) and the plane-index multiply
// run combinationally into the result register. Throughput is one pixel per
// clock whenever the sink takes results; a beat can wait in the input
// register while the result register is full and not drained. Only the
// column/row counters carry across pixels, and they advance as each pixel
// moves into the result register.
// Depends on rdn_pkg, rdn_apb_regs, rdn_normalize, rdn_raster and the macros.
`include "rgb_deinterleave_normalize_macros.svh"
module rgb_deinterleave_normalize
    import rdn_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_beat_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_beat_t            m_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    cfg_t      cfg;
    logic      in_vld_reg, in_vld_next;
    in_beat_t  in_reg;
    logic      out_vld_reg, out_vld_next;
    out_beat_t out_reg;
    out_beat_t result;
    logic      advance;
    logic [7:0] px [4];

    rdn_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // stage 1 moves on when the result register is empty or being drained
    assign advance      = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready      = !in_vld_reg || advance;
    assign in_vld_next  = (s_valid && s_ready) ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
    assign out_vld_next = advance ? 1'b1 : (m_ready ? 1'b0 : out_vld_reg);

    assign px[0] = in_reg.pixel_byte_0;
    assign px[1] = in_reg.pixel_byte_1;
    assign px[2] = in_reg.pixel_byte_2;
    assign px[3] = in_reg.pixel_byte_3;

    rdn_normalize u_norm_red (
        .sample (px[cfg.channel_map[1:0]]),
        .coef   (cfg.red_coef),
        .value  (result.red_value)
    );

    rdn_normalize u_norm_green (
        .sample (px[cfg.channel_map[3:2]]),
        .coef   (cfg.green_coef),
        .value  (result.green_value)
    );

    rdn_normalize u_norm_blue (
        .sample (px[cfg.channel_map[5:4]]),
        .coef   (cfg.blue_coef),
        .value  (result.blue_value)
    );

    rdn_raster u_raster (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .advance     (advance),
        .plane_index (result.plane_index),
        .frame_end   (result.frame_end)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    `RDN_ASSERT_NEXT(a_result_loads, aclk, aresetn, advance, m_valid,
        "advanced beat not presented")
    `RDN_ASSERT_IMPLY(a_full_stall, aclk, aresetn, in_vld_reg && m_valid && !m_ready,
        !s_ready, "accepting while both stages are stalled")
    `RDN_ASSERT_NEXT(a_accept_fills, aclk, aresetn, s_valid && s_ready, in_vld_reg,
        "accepted beat lost in input stage")

endmodule

>>> hw/rtl/rdn_apb_regs.sv
// APB configuration register file: coefficients, channel map, frame geometry.
// Depends on rdn_pkg.
module rdn_apb_regs
    import rdn_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    output cfg_t                 cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t addr_idx;
    logic     wr_en;

    assign pready   = 1'b1;
    assign addr_idx = reg_idx_t'(paddr[ADDR_BITS-1:3]);
    assign wr_en    = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (addr_idx)
                REG_RED_COEF:     cfg_next.red_coef     = pwdata;
                REG_GREEN_COEF:   cfg_next.green_coef   = pwdata;
                REG_BLUE_COEF:    cfg_next.blue_coef    = pwdata;
                REG_CHANNEL_MAP:  cfg_next.channel_map  = pwdata[5:0];
                REG_IMAGE_SIZE:   cfg_next.image_size   = pwdata[31:0];
                REG_OUTPUT_WIDTH: cfg_next.output_width = pwdata[15:0];
                REG_PAD_OFFSET:   cfg_next.pad_offset   = pwdata[31:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.red_coef     <= COEF_RESET;
            cfg_reg.green_coef   <= COEF_RESET;
            cfg_reg.blue_coef    <= COEF_RESET;
            cfg_reg.channel_map  <= CHANNEL_MAP_RESET;
            cfg_reg.image_size   <= '0;
            cfg_reg.output_width <= OUT_WIDTH_RESET;
            cfg_reg.pad_offset   <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (addr_idx)
            REG_RED_COEF:     prdata = cfg_reg.red_coef;
            REG_GREEN_COEF:   prdata = cfg_reg.green_coef;
            REG_BLUE_COEF:    prdata = cfg_reg.blue_coef;
            REG_CHANNEL_MAP:  prdata = 64'(cfg_reg.channel_map);
            REG_IMAGE_SIZE:   prdata = 64'(cfg_reg.image_size);
            REG_OUTPUT_WIDTH: prdata = 64'(cfg_reg.output_width);
            REG_PAD_OFFSET:   prdata = 64'(cfg_reg.pad_offset);
            default:          prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/rdn_normalize.sv
// One channel of the affine normalizer: byte * Q8.24 gain + Q16.16 offset,
// rounded to Q16.16 and saturated. Depends on rdn_pkg (style only).
module rdn_normalize
    import rdn_pkg::*;
(
    input  logic [7:0]         sample,
    input  logic [63:0]        coef,
    output logic signed [31:0] value
);

    logic signed [31:0] gain;
    logic signed [31:0] offs;
    logic signed [40:0] prod;
    logic signed [41:0] sum;
    logic signed [33:0] quot;

    assign gain = $signed(coef[31:0]);
    assign offs = $signed(coef[63:32]);

    // Q.24 sum plus half an LSB of Q16.16; arithmetic shift rounds half up
    assign prod = 41'($signed({1'b0, sample})) * 41'(gain);
    assign sum  = 42'(prod) + (42'(offs) <<< 8) + 42'sd128;
    assign quot = sum[41:8];

    always_comb begin
        if (quot[33:31] == 3'b000 || quot[33:31] == 3'b111) begin
            value = quot[31:0];
        end else if (quot[33]) begin
            value = 32'sh8000_0000;
        end else begin
            value = 32'sh7FFF_FFFF;
        end
    end

endmodule

>>> hw/rtl/rdn_raster.sv
// Raster column/row counters, letterboxed plane index and frame-end flag.
// Depends on rdn_pkg and the assertion macro header.
`include "rgb_deinterleave_normalize_macros.svh"
module rdn_raster
    import rdn_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        advance,
    output logic [31:0] plane_index,
    output logic        frame_end
);

    logic [DIM_BITS-1:0] col_reg, col_next;
    logic [DIM_BITS-1:0] row_reg, row_next;
    logic [DIM_BITS-1:0] src_w, src_h;
    logic [DIM_BITS:0]   col_inc, row_inc;
    logic                last_col, last_row;
    logic [16:0]         row_term;
    logic [32:0]         row_prod;
    logic [33:0]         idx_sum;

    assign src_w   = cfg.image_size[DIM_BITS-1:0];
    assign src_h   = cfg.image_size[16+DIM_BITS-1:16];
    assign col_inc = {1'b0, col_reg} + 1'b1;
    assign row_inc = {1'b0, row_reg} + 1'b1;

    // width or height of zero behaves as one
    assign last_col = col_inc >= {1'b0, src_w};
    assign last_row = row_inc >= {1'b0, src_h};

    assign row_term    = 17'(row_reg) + 17'(cfg.pad_offset[31:16]);
    assign row_prod    = 33'(row_term) * 33'(cfg.output_width);
    assign idx_sum     = 34'(row_prod) + 34'(cfg.pad_offset[15:0]) + 34'(col_reg);
    assign plane_index = idx_sum[31:0];
    assign frame_end   = last_col && last_row;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_inc[DIM_BITS-1:0];
            end else begin
                col_next = col_inc[DIM_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    `RDN_ASSERT_NEXT(a_frame_wrap, aclk, aresetn, advance && frame_end, col_reg == '0 && row_reg == '0, "counters did not wrap at frame end")
    `RDN_ASSERT_NEXT(a_count_hold, aclk, aresetn, !advance, $stable(col_reg) && $stable(row_reg), "counters moved without a pixel")

endmodule

>>> tb/rgb_deinterleave_normalize_tb.sv
// Self-checking testbench for rgb_deinterleave_normalize: pixel stream in, normalized
// planar samples out, registers written over APB between bursts.
// Depends on rdn_pkg and the rgb_deinterleave_normalize RTL only.
`timescale 1ns / 100ps

module rgb_deinterleave_normalize_tb;
    import rdn_pkg::*;

    localparam int RANDOM_PIXELS = 1250;
    localparam int SETTLE_CYCLES = 4;     // input and result registers plus margin
    localparam int STALL_LIMIT   = 2000;  // cycles with no beat moving
    localparam int HOLD_CYCLES   = 200;

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_beat_t             s_data  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_beat_t            m_data;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_BITS-1:0] paddr   = '0;
    logic [DATA_BITS-1:0] pwdata  = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    rgb_deinterleave_normalize dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Shadow of the register file and the raster counters
    cfg_t                shadow_cfg;
    logic [DIM_BITS-1:0] col_cnt;
    logic [DIM_BITS-1:0] row_cnt;
    out_beat_t           norm_results[$];

    int  mismatches  = 0;
    int  compared    = 0;
    int  frames_seen = 0;
    int  pixels_sent = 0;
    int  reg_writes  = 0;
    int  stall_run   = 0;
    int  hold_cycles = 0;
    bit  calm        = 1'b0;
    out_beat_t want;

    typedef struct {
        bit          is_cfg;
        reg_idx_t    idx;
        logic [63:0] val;
        in_beat_t    px;
        bit          typed;
        out_beat_t   res;
    } plan_row_t;

    // Directed opening. Typed results only for the post-reset rows, where width and
    // height are zero so every pixel closes a frame at index 0 with unity gain.
    plan_row_t plan [41] = '{
        '{0, REG_RED_COEF, 64'h0, 32'h0000_0000, 1, {32'h0, 32'h0, 32'h0, 32'h0, 1'b1}},
        '{0, REG_RED_COEF, 64'h0, 32'hFFFF_FFFF, 1,
          {32'h0, 32'h00FF_0000, 32'h00FF_0000, 32'h00FF_0000, 1'b1}},
        '{0, REG_RED_COEF, 64'h0, 32'h1234_5678, 1,
          {32'h0, 32'h0012_0000, 32'h0034_0000, 32'h0056_0000, 1'b1}},
        '{1, REG_IMAGE_SIZE,   64'h0002_0003, 32'h0, 0, '0},
        '{1, REG_OUTPUT_WIDTH, 64'd5,         32'h0, 0, '0},
        '{1, REG_PAD_OFFSET,   64'h0001_0002, 32'h0, 0, '0},
        '{0, REG_RED_COEF, 64'h0, 32'h0102_0304, 0, '0},
        '{0, REG_RED_COEF, 64'h0, 32'h8080_8080, 0, '0},
        '{0, REG_RED_COEF, 64'h0, 32'h7F7F_7F7F, 0, '0},
        '{0, REG_RED_COEF, 64'h0, 32'h00FF_00FF, 0, '0},
        '{0, REG_RED_COEF, 64'h0, 32'hFF00_FF00, 0, '0},
        '{0, REG_RED_COEF, 64'h0, 32'hA5C3_5A3C, 0, '0},
        '{1, REG_CHANNEL_MAP, 64'h3F, 32'h0, 0, '0},
        '{0, REG_RED_COEF, 64'h0, 32'h0102_03AB, 0, '0},
        '{1, REG_CHANNEL_MAP, 64'h1B, 32'h0, 0, '0},
        '{0, REG_RED_COEF, 64'h0, 32'h1122_3344, 0, '0},
        '{1, REG_CHANNEL_MAP, 64'h00, 32'h0, 0, '0},
        '{0, REG_RED_COEF, 64'h0, 32'h5566_7788, 0, '0},
        '{1, REG_CHANNEL_MAP, 64'd36, 32'h0, 0, '0},
        // saturation both ways, and a gain of one half LSB for rounding
        '{1, REG_RED_COEF,   64'h7FFF_FFFF_7FFF_FFFF, 32'h0, 0, '0},
        '{1, REG_GREEN_COEF, 64'h8000_0000_8000_0000, 32'h0, 0, '0},
        '{1, REG_BLUE_COEF,  64'h0000_0000_0000_0080, 32'h0, 0, '0},
        '{0, REG_RED_COEF, 64'h0, 32'hFFFF_0100, 0, '0},
        '{0, REG_RED_COEF, 64'h0, 32'h0000_FF00, 0, '0},
        '{0, REG_RED_COEF, 64'h0, 32'h0000_0000, 0, '0},
        // negative half rounds toward plus infinity; offset at the minimum, gain zero
        '{1, REG_BLUE_COEF,  64'h0000_0000_FFFF_FF80, 32'h0, 0, '0},
        '{1, REG_GREEN_COEF, 64'h8000_0000_0000_0000, 32'h0, 0, '0},
        '{0, REG_RED_COEF, 64'h0, 32'h0101_0101, 0, '0},
        '{0, REG_RED_COEF, 64'h0, 32'h0303_0303, 0, '0},
        // plane index wraps past 2^32; counters mid-frame across size changes
        '{1, REG_OUTPUT_WIDTH, 64'hFFFF,      32'h0, 0, '0},
        '{1, REG_PAD_OFFSET,   64'hFFFF_FFFF, 32'h0, 0, '0},
        '{1, REG_IMAGE_SIZE,   64'hFFFF_FFFF, 32'h0, 0, '0},
        '{0, REG_RED_COEF, 64'h0, 32'hDEAD_BEEF, 0, '0},
        '{0, REG_RED_COEF, 64'h0, 32'h0F0F_0F0F, 0, '0},
        '{0, REG_RED_COEF, 64'h0, 32'hF0F0_F0F0, 0, '0},
        '{1, REG_IMAGE_SIZE,   64'h0001_0000, 32'h0, 0, '0},
        '{0, REG_RED_COEF, 64'h0, 32'hC0FF_EE00, 0, '0},
        '{0, REG_RED_COEF, 64'h0, 32'h0000_0001, 0, '0},
        '{1, REG_IMAGE_SIZE,   64'h0000_0004, 32'h0, 0, '0},
        '{0, REG_RED_COEF, 64'h0, 32'h1357_9BDF, 0, '0},
        '{0, REG_RED_COEF, 64'h0, 32'h2468_ACE0, 0, '0}
    };

    // byte * gain(Q8.24) + offset(Q16.16), one rounding to Q16.16, then clamp
    function automatic logic signed [31:0] affine_q16(logic [7:0] v, logic [63:0] coef);
        longint signed gain;
        longint signed offs;
        longint signed acc;
        gain = longint'(signed'(coef[31:0]));
        offs = longint'(signed'(coef[63:32]));
        acc  = (longint'(v) * gain + offs * 256 + 128) >>> 8;
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        return acc[31:0];
    endfunction

    // Result for one pixel at the current raster position; advances the counters.
    function automatic out_beat_t raster_normalize(in_beat_t px);
        out_beat_t           res;
        logic [7:0]          lane [4];
        logic [5:0]          map;
        logic [DIM_BITS-1:0] src_w;
        logic [DIM_BITS-1:0] src_h;
        logic [63:0]         idx;
        bit                  last_col;
        bit                  last_row;
        lane[0] = px.pixel_byte_0;
        lane[1] = px.pixel_byte_1;
        lane[2] = px.pixel_byte_2;
        lane[3] = px.pixel_byte_3;
        map   = shadow_cfg.channel_map;
        src_w = shadow_cfg.image_size[DIM_BITS-1:0];
        src_h = shadow_cfg.image_size[16 +: DIM_BITS];
        last_col = (int'(col_cnt) + 1) >= int'(src_w);
        last_row = (int'(row_cnt) + 1) >= int'(src_h);
        idx = (64'(row_cnt) + 64'(shadow_cfg.pad_offset[31:16]))
              * 64'(shadow_cfg.output_width)
              + 64'(shadow_cfg.pad_offset[15:0]) + 64'(col_cnt);
        res.plane_index = idx[31:0];
        res.red_value   = affine_q16(lane[map[1:0]], shadow_cfg.red_coef);
        res.green_value = affine_q16(lane[map[3:2]], shadow_cfg.green_coef);
        res.blue_value  = affine_q16(lane[map[5:4]], shadow_cfg.blue_coef);
        res.frame_end   = last_col && last_row;
        if (last_col) begin
            col_cnt = '0;
            row_cnt = last_row ? '0 : row_cnt + 1'b1;
        end else begin
            col_cnt = col_cnt + 1'b1;
        end
        return res;
    endfunction

    function automatic logic [63:0] draw_setting(reg_idx_t r);
        logic [31:0] ext [4] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        int signed   g;
        int signed   o;
        case (r)
            REG_RED_COEF, REG_GREEN_COEF, REG_BLUE_COEF: begin
                g = $signed($urandom) >>> 6;
                o = $signed($urandom) >>> 8;
                case ($urandom_range(4))
                    0: return {$urandom, $urandom};
                    1: return {o, g};
                    2: return {ext[$urandom_range(3)], ext[$urandom_range(3)]};
                    3: return COEF_RESET;
                    default: return {32'h0, g >>> 14};  // tiny gains, rounding matters
                endcase
            end
            REG_CHANNEL_MAP: return 64'($urandom_range(63));
            REG_IMAGE_SIZE: begin
                case ($urandom_range(5))
                    0: return 64'h0;
                    1: return {32'h0, 16'($urandom_range(1, 6)), 16'($urandom_range(1, 9))};
                    2: return {32'h0, 16'd1, 16'($urandom_range(1, 40))};
                    3: return 64'($urandom);
                    4: return 64'hFFFF_FFFF;
                    default: return 64'h0001_0001;
                endcase
            end
            REG_OUTPUT_WIDTH: begin
                case ($urandom_range(3))
                    0: return 64'd1;
                    1: return 64'hFFFF;
                    2: return 64'($urandom_range(1, 64));
                    default: return 64'($urandom_range(1, 65535));
                endcase
            end
            default: begin
                case ($urandom_range(3))
                    0: return 64'h0;
                    1: return 64'hFFFF_FFFF;
                    2: return {32'h0, 16'($urandom_range(8)), 16'($urandom_range(8))};
                    default: return 64'($urandom);
                endcase
            end
        endcase
    endfunction

    // Register write over APB; only once the pipe has drained.
    task automatic write_reg(reg_idx_t r, logic [63:0] v);
        s_valid <= 1'b0;
        while (norm_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 3'b000};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_RED_COEF:     shadow_cfg.red_coef     = v;
            REG_GREEN_COEF:   shadow_cfg.green_coef   = v;
            REG_BLUE_COEF:    shadow_cfg.blue_coef    = v;
            REG_CHANNEL_MAP:  shadow_cfg.channel_map  = v[5:0];
            REG_IMAGE_SIZE:   shadow_cfg.image_size   = v[31:0];
            REG_OUTPUT_WIDTH: shadow_cfg.output_width = v[15:0];
            REG_PAD_OFFSET:   shadow_cfg.pad_offset   = v[31:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Offer one pixel, hold it until taken, then maybe leave a gap.
    // Gaps after 8% of beats idle the source about a fifth of the time.
    task automatic send_pixel(in_beat_t px, bit typed, out_beat_t typed_res);
        out_beat_t res;
        s_valid <= 1'b1;
        s_data  <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        res = raster_normalize(px);
        norm_results.push_back(typed ? typed_res : res);
        pixels_sent++;
        if (!calm && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // Sink side: random back-pressure, plus a long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_cycles != 0) begin
                m_ready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end
            m_ready <= calm || ($urandom_range(99) >= 21);
        end
    end

    // Result scoreboard and stall watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_run = 0;
            end else begin
                stall_run++;
                if (stall_run >= STALL_LIMIT) begin
                    $display("Regression FAIL");
                    $finish;
                end
            end
            if (m_valid && m_ready) begin
                if (norm_results.size() == 0) begin
                    $error("result beat with nothing pending, plane_index %h",
                           m_data.plane_index);
                    mismatches++;
                end else begin
                    want = norm_results.pop_front();
                    check_field("plane_index", want.plane_index, m_data.plane_index);
                    check_field("red_value",   want.red_value,   m_data.red_value);
                    check_field("green_value", want.green_value, m_data.green_value);
                    check_field("blue_value",  want.blue_value,  m_data.blue_value);
                    check_field("frame_end",   32'(want.frame_end), 32'(m_data.frame_end));
                    compared++;
                    if (m_data.frame_end) frames_seen++;
                end
            end
        end
    end

    initial begin
        int n;
        int phase;
        int random_sent;
        shadow_cfg = '{COEF_RESET, COEF_RESET, COEF_RESET, CHANNEL_MAP_RESET,
                       32'h0, OUT_WIDTH_RESET, 32'h0};
        col_cnt     = '0;
        row_cnt     = '0;
        phase       = 0;
        random_sent = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].val);
            else send_pixel(plan[i].px, plan[i].typed, plan[i].res);
        end

        while (random_sent < RANDOM_PIXELS) begin
            calm = (phase >= 6 && phase < 9);
            for (int r = 0; r <= int'(REG_PAD_OFFSET); r++) begin
                if (phase == 0 || $urandom_range(1))
                    write_reg(reg_idx_t'(r), draw_setting(reg_idx_t'(r)));
            end
            n = $urandom_range(20, 80);
            for (int k = 0; k < n; k++) begin
                // sink stalls for a long while; source keeps pushing until it backs up
                if (phase == 3 && k == 5) hold_cycles = HOLD_CYCLES;
                // source goes quiet until everything in flight has come out
                if (phase == 11 && k == n / 2) begin
                    s_valid <= 1'b0;
                    do @(posedge aclk); while (norm_results.size() != 0);
                end
                send_pixel(in_beat_t'($urandom), 1'b0, '0);
                random_sent++;
            end
            phase++;
        end

        s_valid <= 1'b0;
        calm = 1'b0;
        while (norm_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES * 2) @(posedge aclk);

        $display("Sent %0d pixels over %0d register writes in %0d random phases;",
                 pixels_sent, reg_writes, phase);
        $display("checked %0d result beats, %0d of them closing a frame.",
                 compared, frames_seen);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
